// ----- rtl/core/lorentz_boost_top_defines.svh -----
// Assertion macros for the Lorentz boost block.
`ifndef LORENTZ_BOOST_TOP_DEFINES_SVH
`define LORENTZ_BOOST_TOP_DEFINES_SVH
// Implication checked on every rising edge, off during reset.
`define LB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, off during reset.
`define LB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/lb_pkg.sv -----
// Shared constants and helpers for the Lorentz boost block.
package lb_pkg;
  localparam logic [63:0] OneQ60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] OneQ30 = 64'h0000_0000_4000_0000;
  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  // Saturate a wide signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) r = SatMax;
    else if (v < -67'sd2147483648) r = SatMin;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// ----- rtl/core/lb_sqrt.sv -----
// Pipelined integer square root of a 64-bit value, carrying a side tag.
module lb_sqrt #(
  parameter int unsigned TagW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     in_val,
  input  logic [TagW-1:0] in_tag,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output logic [TagW-1:0] out_tag
);
  // one result bit per stage, 32 stages
  localparam int unsigned N = 32;
  logic [63:0]     rem_r [N+1];
  logic [31:0]     root_r [N+1];
  logic [TagW-1:0] tag_r [N+1];
  logic [N:0]      vld_r;

  always_comb begin
    rem_r[0]  = in_val;
    root_r[0] = '0;
    tag_r[0]  = in_tag;
    vld_r[0]  = in_valid;
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam int unsigned Sh = 2 * (N - 1 - k);
    logic [65:0] trial;
    logic [65:0] remsh;
    always_comb begin
      trial = ({34'd0, root_r[k]} << (Sh + 2)) | (66'd1 << Sh);
      remsh = {2'b00, rem_r[k]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        tag_r[k+1] <= tag_r[k];
        if (remsh >= trial) begin
          rem_r[k+1]  <= rem_r[k] - trial[63:0];
          root_r[k+1] <= {root_r[k][30:0], 1'b1};
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= {root_r[k][30:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_root  = root_r[N];
  assign out_tag   = tag_r[N];
endmodule

// ----- rtl/core/lb_div.sv -----
// Pipelined restoring divider: 2^60 / d, 61-bit quotient, carrying a side tag.
module lb_div #(
  parameter int unsigned TagW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     in_den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_valid,
  output logic [63:0]     out_quo,
  output logic [TagW-1:0] out_tag
);
  // one quotient bit per stage
  localparam int unsigned N = 61;
  logic [64:0]     rem_r [N+1];
  logic [63:0]     quo_r [N+1];
  logic [63:0]     den_r [N+1];
  logic [TagW-1:0] tag_r [N+1];
  logic [N:0]      vld_r;

  always_comb begin
    rem_r[0] = '0;
    quo_r[0] = '0;
    den_r[0] = in_den;
    tag_r[0] = in_tag;
    vld_r[0] = in_valid;
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    // dividend bit entering here: only the top one of 2^60 is set
    localparam logic Bit = (k == 0);
    logic [64:0] sh;
    always_comb sh = {rem_r[k][63:0], Bit};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        tag_r[k+1] <= tag_r[k];
        den_r[k+1] <= den_r[k];
        if (sh >= {1'b0, den_r[k]}) begin
          rem_r[k+1] <= sh - {1'b0, den_r[k]};
          quo_r[k+1] <= {quo_r[k][62:0], 1'b1};
        end else begin
          rem_r[k+1] <= sh;
          quo_r[k+1] <= {quo_r[k][62:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_quo   = quo_r[N];
  assign out_tag   = tag_r[N];
endmodule

// ----- rtl/core/lorentz_boost_top.sv -----
// Lorentz boost pipeline: one particle's momentum per cycle unless stalled.
//
// Input channel in_*: one request per particle (momentum, rest mass, beta),
// taken when in_valid is high and in_stall is low. Result channel out_*:
// boosted momentum and fault flag, one result per request, in order.
// Throughput: one request per cycle while out_stall does not freeze it. The
// pipeline has 161 register stages (2 + 32 + 61 + 61 + 5); the bit-per-stage
// square root (sqrt of 1-b2) and the two dividers (2^60/s, 2^60/(G+1)) make
// up most of them; the energy square root runs in parallel with the beta
// square root.
// When a valid result waits under out_stall, the whole pipeline freezes and
// in_stall is raised, so nothing is lost or repeated; a request waiting in
// front is held.
// Reset (rst_n low, synchronous) clears every valid bit; payload registers
// are not reset. Beta squared at least one yields zero momentum and fault.
// Saturated components clamp to the 32-bit range and set fault.
`include "lorentz_boost_top_defines.svh"
module lorentz_boost_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_mom_x,
  input  logic signed [31:0] in_mom_y,
  input  logic signed [31:0] in_mom_z,
  input  logic [30:0]        in_rest_mass,
  input  logic signed [30:0] in_beta_x,
  input  logic signed [30:0] in_beta_y,
  input  logic signed [30:0] in_beta_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_out_x,
  output logic signed [31:0] out_out_y,
  output logic signed [31:0] out_out_z,
  output logic               out_fault
);
  // carried item: momentum, beta, energy-squared later replaced
  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [30:0] bx, by, bz;
    logic               inv;
    logic [63:0]        e2;
  } item_t;

  typedef struct packed {
    item_t       it;
    logic [31:0] e;
    logic [63:0] g;
  } item2_t;

  localparam int unsigned TW1 = $bits(item_t);
  localparam int unsigned TW2 = $bits(item2_t);

  // global freeze when the output holds a result that is stalled
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage A: squares of beta, momentum and rest mass, and beta*momentum
  logic        a_v_r;
  item_t       a_it_r;
  item_t       a_it_nxt;
  logic [61:0] a_bb_r [3];
  logic [63:0] a_pp_r [3];
  logic [61:0] a_mm_r;
  logic signed [62:0] a_bp_r [3];
  always_comb begin
    a_it_nxt    = '0;
    a_it_nxt.px = in_mom_x;
    a_it_nxt.py = in_mom_y;
    a_it_nxt.pz = in_mom_z;
    a_it_nxt.bx = in_beta_x;
    a_it_nxt.by = in_beta_y;
    a_it_nxt.bz = in_beta_z;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= in_valid;
    if (en) begin
      a_it_r    <= a_it_nxt;
      a_bb_r[0] <= 62'(in_beta_x * in_beta_x);
      a_bb_r[1] <= 62'(in_beta_y * in_beta_y);
      a_bb_r[2] <= 62'(in_beta_z * in_beta_z);
      a_pp_r[0] <= 64'(in_mom_x * in_mom_x);
      a_pp_r[1] <= 64'(in_mom_y * in_mom_y);
      a_pp_r[2] <= 64'(in_mom_z * in_mom_z);
      a_mm_r    <= 62'(in_rest_mass * in_rest_mass);
      a_bp_r[0] <= 63'(in_beta_x * in_mom_x);
      a_bp_r[1] <= 63'(in_beta_y * in_mom_y);
      a_bp_r[2] <= 63'(in_beta_z * in_mom_z);
    end
  end

  // stage B: sums, b2 range check, 1 - b2
  logic        b_v_r;
  item_t       b_it_r;
  item_t       b_it_nxt;
  logic [63:0] b_rad_r;
  logic signed [64:0] b_bp_r;
  logic [63:0] bsum;
  always_comb bsum = 64'(a_bb_r[0]) + 64'(a_bb_r[1]) + 64'(a_bb_r[2]);
  always_comb begin
    b_it_nxt     = a_it_r;
    b_it_nxt.inv = bsum >= lb_pkg::OneQ60;
    b_it_nxt.e2  = a_pp_r[0] + a_pp_r[1] + a_pp_r[2] + 64'(a_mm_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
    if (en) begin
      b_it_r  <= b_it_nxt;
      b_rad_r <= (bsum >= lb_pkg::OneQ60) ? 64'd1 : lb_pkg::OneQ60 - bsum;
      b_bp_r  <= 65'(a_bp_r[0]) + 65'(a_bp_r[1]) + 65'(a_bp_r[2]);
    end
  end

  // b.p rides in the energy root's tag, the item's e2 slot being busy
  // sqrt of energy squared and of 1 - b2 in parallel
  logic        s_v, e_v;
  logic [31:0] s_root, e_root;
  logic [TW1-1:0] s_tag;
  logic [64:0] e_tag;
  lb_sqrt #(.TagW(TW1)) u_sq_b (
    .clk, .rst_n, .en, .in_valid(b_v_r), .in_val(b_rad_r), .in_tag(b_it_r),
    .out_valid(s_v), .out_root(s_root), .out_tag(s_tag));
  lb_sqrt #(.TagW(65)) u_sq_e (
    .clk, .rst_n, .en, .in_valid(b_v_r), .in_val(b_it_r.e2), .in_tag(b_bp_r),
    .out_valid(e_v), .out_root(e_root), .out_tag(e_tag));

  // gamma = 2^60 / s ; tag carries item (e packed into e2 field) and b.p
  item_t g_in;
  always_comb begin
    g_in    = item_t'(s_tag);
    g_in.e2 = {32'd0, e_root};
  end
  logic          g_v;
  logic [63:0]   g_quo;
  logic [TW1+64:0] g_tag;
  lb_div #(.TagW(TW1 + 65)) u_div_g (
    .clk, .rst_n, .en, .in_valid(s_v), .in_den({32'd0, s_root}),
    .in_tag({g_in, e_tag}), .out_valid(g_v), .out_quo(g_quo), .out_tag(g_tag));

  // second divide by G + 1
  item2_t h_in;
  always_comb begin
    h_in.it = g_tag[TW1+64:65];
    h_in.e  = h_in.it.e2[31:0];
    h_in.g  = g_quo;
  end
  logic          h_v;
  logic [63:0]   h_quo;
  logic [TW2+64:0] h_tag;
  lb_div #(.TagW(TW2 + 65)) u_div_h (
    .clk, .rst_n, .en, .in_valid(g_v), .in_den(g_quo + lb_pkg::OneQ30),
    .in_tag({h_in, g_tag[64:0]}), .out_valid(h_v), .out_quo(h_quo),
    .out_tag(h_tag));

  // stage C: H and |b.p|
  item2_t c_it_r;
  logic   c_v_r;
  logic [63:0] c_h_r, c_bpm_r;
  logic        c_bpn_r;
  item2_t hq;
  logic signed [64:0] hbp;
  always_comb begin
    hq  = h_tag[TW2+64:65];
    hbp = h_tag[64:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= h_v;
    if (en) begin
      c_it_r  <= hq;
      c_h_r   <= hq.g - lb_pkg::OneQ30 + h_quo;
      c_bpn_r <= hbp[64];
      c_bpm_r <= hbp[64] ? 64'(-hbp) : hbp[63:0];
    end
  end

  // stages D1-D2: u = H*|bp| >> 60 and ge = G*E >> 30, split 32x32 partials
  logic   d1_v_r;
  item2_t d1_it_r;
  logic   d1_bpn_r;
  logic [63:0] d1_u00_r, d1_u01_r, d1_u10_r, d1_u11_r;
  logic [63:0] d1_g0_r, d1_g1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r <= 1'b0;
    else if (en) d1_v_r <= c_v_r;
    if (en) begin
      d1_it_r  <= c_it_r;
      d1_bpn_r <= c_bpn_r;
      d1_u00_r <= c_h_r[31:0] * c_bpm_r[31:0];
      d1_u01_r <= c_h_r[31:0] * c_bpm_r[63:32];
      d1_u10_r <= c_h_r[63:32] * c_bpm_r[31:0];
      d1_u11_r <= c_h_r[63:32] * c_bpm_r[63:32];
      d1_g0_r  <= c_it_r.g[31:0] * c_it_r.e;
      d1_g1_r  <= c_it_r.g[63:32] * c_it_r.e;
    end
  end

  logic   d2_v_r;
  item2_t d2_it_r;
  logic   d2_bpn_r;
  logic [63:0] d2_u_r, d2_ge_r;
  logic [127:0] usum;
  logic [95:0]  gsum;
  always_comb begin
    usum = {64'd0, d1_u00_r} + ({64'd0, d1_u01_r} << 32) + ({64'd0, d1_u10_r} << 32)
         + ({d1_u11_r, 64'd0});
    gsum = {32'd0, d1_g0_r} + ({32'd0, d1_g1_r} << 32);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r <= 1'b0;
    else if (en) d2_v_r <= d1_v_r;
    if (en) begin
      d2_it_r  <= d1_it_r;
      d2_bpn_r <= d1_bpn_r;
      d2_u_r   <= usum[123:60];
      d2_ge_r  <= gsum[93:30];
    end
  end

  // stage E: per-axis terms u*|b| >> 30 and ge*|b| >> 30, split partials
  logic   e_v_r;
  item2_t e_it_r;
  logic   e_bpn_r;
  logic [63:0] e_u0_r [3], e_u1_r [3], e_g0_r [3], e_g1_r [3];
  // |b| reaches 2^30, so it takes 31 bits
  logic [30:0] mbw [3];
  always_comb begin
    mbw[0] = d2_it_r.it.bx[30] ? 31'(-d2_it_r.it.bx) : 31'(d2_it_r.it.bx);
    mbw[1] = d2_it_r.it.by[30] ? 31'(-d2_it_r.it.by) : 31'(d2_it_r.it.by);
    mbw[2] = d2_it_r.it.bz[30] ? 31'(-d2_it_r.it.bz) : 31'(d2_it_r.it.bz);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (en) e_v_r <= d2_v_r;
    if (en) begin
      e_it_r  <= d2_it_r;
      e_bpn_r <= d2_bpn_r;
      for (int i = 0; i < 3; i++) begin
        e_u0_r[i] <= d2_u_r[31:0] * {1'b0, mbw[i]};
        e_u1_r[i] <= d2_u_r[63:32] * {1'b0, mbw[i]};
        e_g0_r[i] <= d2_ge_r[31:0] * {1'b0, mbw[i]};
        e_g1_r[i] <= d2_ge_r[63:32] * {1'b0, mbw[i]};
      end
    end
  end

  // stage F: assemble terms, signs, sum, saturate
  logic         f_v_r;
  logic signed [31:0] f_o_r [3];
  logic         f_fault_r;
  logic [95:0]  t1w [3], t2w [3];
  logic [63:0]  t1 [3], t2 [3];
  logic signed [66:0] acc [3];
  logic signed [31:0] sat [3];
  logic [2:0]   ovf;
  logic         bneg [3];
  always_comb begin
    bneg[0] = e_it_r.it.bx[30];
    bneg[1] = e_it_r.it.by[30];
    bneg[2] = e_it_r.it.bz[30];
    for (int i = 0; i < 3; i++) begin
      t1w[i] = {32'd0, e_u0_r[i]} + ({32'd0, e_u1_r[i]} << 32);
      t2w[i] = {32'd0, e_g0_r[i]} + ({32'd0, e_g1_r[i]} << 32);
      t1[i]  = t1w[i][93:30];
      t2[i]  = t2w[i][93:30];
      acc[i] = 67'(e_it_r.it.px) ;
      if (i == 1) acc[i] = 67'(e_it_r.it.py);
      if (i == 2) acc[i] = 67'(e_it_r.it.pz);
      acc[i] = bneg[i] ? acc[i] - $signed({3'b000, t2[i]})
                       : acc[i] + $signed({3'b000, t2[i]});
      acc[i] = (bneg[i] != e_bpn_r) ? acc[i] - $signed({3'b000, t1[i]})
                                    : acc[i] + $signed({3'b000, t1[i]});
      sat[i] = lb_pkg::sat32(acc[i]);
      ovf[i] = acc[i] != 67'(sat[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (en) f_v_r <= e_v_r;
    if (en) begin
      for (int i = 0; i < 3; i++) f_o_r[i] <= e_it_r.it.inv ? 32'sd0 : sat[i];
      f_fault_r <= e_it_r.it.inv || (|ovf);
    end
  end

  assign out_valid = f_v_r;
  assign out_out_x = f_o_r[0];
  assign out_out_y = f_o_r[1];
  assign out_out_z = f_o_r[2];
  assign out_fault = f_fault_r;

  // pipeline checks
  `LB_ASSERT_NXT(a_hold, out_valid && out_stall, $stable(out_out_x) && out_valid)
  `LB_ASSERT_IMP(a_stall_only, in_stall, out_valid && out_stall)
  `LB_ASSERT_NXT(a_adv, !in_stall, f_v_r == $past(e_v_r))
  `LB_ASSERT_IMP(a_sq_align, s_v || e_v, s_v && e_v)
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the Lorentz boost pipeline: directed table then random particles.
`timescale 1ns / 1ps
module tb_top;
  localparam int unsigned LATENCY = 161;
  localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ONE30 = 64'h0000_0000_4000_0000;
  localparam logic [30:0] BMAX = 31'h3FFF_FFFF;
  localparam logic [30:0] BMIN = 31'h4000_0000;
  localparam int unsigned N_RANDOM = 440;
  localparam int unsigned N_HOLD = 200;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [30:0] mass;
    logic [30:0] bx, by, bz;
  } particle_t;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        fault;
  } boosted_t;

  // Directed row: known marks whether the typed-in result is valid.
  typedef struct packed {
    particle_t p;
    logic      known;
    boosted_t  r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_mom_x = '0, in_mom_y = '0, in_mom_z = '0;
  logic [30:0] in_rest_mass = '0;
  logic signed [30:0] in_beta_x = '0, in_beta_y = '0, in_beta_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_out_x, out_out_y, out_out_z;
  logic out_fault;

  boosted_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  bit stim_done = 1'b0;

  lorentz_boost_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r, b, v;
    r = 0; b = 64'd1 << 62; v = n;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Boosted momentum of one particle, bit exact.
  function automatic boosted_t boost(input particle_t q);
    logic signed [63:0] p[3], b[3];
    logic signed [63:0] bp;
    logic [63:0] m, e2, b2, e, s, g, h, u, ge, bpm, mb, t1, t2;
    logic [127:0] w;
    logic signed [65:0] a;
    logic [31:0] o[3];
    boosted_t r;
    r = '0;
    p[0] = 64'(signed'(q.px)); p[1] = 64'(signed'(q.py)); p[2] = 64'(signed'(q.pz));
    b[0] = 64'(signed'(q.bx)); b[1] = 64'(signed'(q.by)); b[2] = 64'(signed'(q.bz));
    m = 64'(q.mass);
    b2 = 0;
    for (int i = 0; i < 3; i++) b2 += mag64(b[i]) * mag64(b[i]);
    if (b2 >= ONE60) begin
      r.fault = 1'b1;
      return r;
    end
    e2 = m * m;
    bp = 0;
    for (int i = 0; i < 3; i++) begin
      e2 += mag64(p[i]) * mag64(p[i]);
      bp += b[i] * p[i];
    end
    e = isqrt(e2);
    s = isqrt(ONE60 - b2);
    g = ONE60 / s;
    h = g - ONE30 + ONE60 / (g + ONE30);
    bpm = mag64(bp);
    w = 128'(h) * 128'(bpm); u = 64'(w >> 60);
    w = 128'(g) * 128'(e); ge = 64'(w >> 30);
    for (int i = 0; i < 3; i++) begin
      mb = mag64(b[i]);
      w = 128'(u) * 128'(mb); t1 = 64'(w >> 30);
      w = 128'(ge) * 128'(mb); t2 = 64'(w >> 30);
      a = 66'(p[i]) + (b[i] < 0 ? -66'(signed'({1'b0, t2})) : 66'(signed'({1'b0, t2})));
      if ((bp < 0) != (b[i] < 0)) a = a - 66'(signed'({1'b0, t1}));
      else a = a + 66'(signed'({1'b0, t1}));
      if (a > 66'sd2147483647) begin
        o[i] = 32'h7FFF_FFFF; r.fault = 1'b1;
      end else if (a < -66'sd2147483648) begin
        o[i] = 32'h8000_0000; r.fault = 1'b1;
      end else begin
        o[i] = a[31:0];
      end
    end
    r.x = o[0]; r.y = o[1]; r.z = o[2];
    return r;
  endfunction

  function automatic logic [30:0] rand_beta(input int unsigned lim);
    int signed v;
    v = int'($urandom_range(2 * lim)) - int'(lim);
    return v[30:0];
  endfunction

  // Random particle; mostly physical beta, sometimes anything.
  function automatic particle_t rand_particle();
    particle_t q;
    int unsigned lim;
    q.px = $urandom; q.py = $urandom; q.pz = $urandom;
    if ($urandom_range(3) != 0) begin
      q.px = 32'(signed'(q.px) >>> $urandom_range(20));
      q.py = 32'(signed'(q.py) >>> $urandom_range(20));
      q.pz = 32'(signed'(q.pz) >>> $urandom_range(20));
    end
    q.mass = 31'($urandom) >> $urandom_range(30);
    case ($urandom_range(3))
      0: lim = 32'h3FFF_FFFF;
      1: lim = 32'h24FF_FFFF;
      default: lim = 32'h3FFF_FFFF >> $urandom_range(1, 12);
    endcase
    q.bx = rand_beta(lim); q.by = rand_beta(lim); q.bz = rand_beta(lim);
    return q;
  endfunction

  // Offer one request and wait until it is taken; valid stays up for the next.
  task automatic send(input particle_t q, input boosted_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_mom_x <= q.px; in_mom_y <= q.py; in_mom_z <= q.pz;
    in_rest_mass <= q.mass;
    in_beta_x <= q.bx; in_beta_y <= q.by; in_beta_z <= q.bz;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(want);
    @(negedge clk);
  endtask

  // Receiver stall, randomized or held off for a counted stretch.
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    boosted_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_out_x, out_out_y, out_out_z, out_fault};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h f=%b got x=%h y=%h z=%h f=%b",
                     want.x, want.y, want.z, want.fault, got.x, got.y, got.z, got.fault);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    particle_t q;
    boosted_t want;
    // Directed rows: zero beta passes momentum, beta at c faults.
    rw = '0; rw.known = 1'b1; rows.push_back(rw);
    rw.p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 31'h7FFF_FFFF, 0, 0, 0};
    rw.r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0}; rows.push_back(rw);
    rw.p = '{32'h1234_5678, 32'h0, 32'h0, 31'h1, BMIN, 0, 0};
    rw.r = '{0, 0, 0, 1'b1}; rows.push_back(rw);
    rw.p = '{32'h0, 32'h0, 32'h0, 31'h0, BMIN, BMIN, BMIN}; rows.push_back(rw);
    rw.known = 1'b0;
    rw.p = '{32'hFFFF_FFFF, 32'h1, 32'h0, 31'h0, 31'h2000_0000, 31'h3000_0000, 0};
    rows.push_back(rw);
    rw.p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, BMAX, 0, 0};
    rows.push_back(rw);
    rw.p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 0, BMAX, 0};
    rows.push_back(rw);
    rw.p = '{32'h0001_0000, 32'h0, 32'h0, 31'h0001_0000, 31'h2000_0000, 0, 0};
    rows.push_back(rw);
    rw.p = '{32'h0, 32'h0, 32'h0, 31'h0001_0000, 0, 0, 31'h7FFF_FFFF - BMAX + 31'h3F00_0000};
    rows.push_back(rw);
    rw.p = '{32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000, 31'h0, 31'h1, 31'h7FFF_FFFF, 31'h1};
    rows.push_back(rw);
    rw.p = '{32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'h2D41_3CCC, 31'h2D41_3CCC, 0};
    rows.push_back(rw);
    rw.p = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 31'h5555_5555, 31'h1555_5555,
             31'h6AAA_AAAA, 31'h0AAA_AAAA};
    rows.push_back(rw);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      want = rows[i].known ? rows[i].r : boost(rows[i].p);
      send(rows[i].p, want);
    end

    // Long receiver hold while requests keep coming; more requests than the
    // pipe holds, so it fills and stalls its input.
    hold_cycles <= 400;
    for (int i = 0; i < N_HOLD; i++) begin
      q = rand_particle();
      send(q, boost(q));
    end
    // Sender pause until everything has drained.
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 48; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 48; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        q = rand_particle();
        send(q, boost(q));
      end
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- lorentz_boost_top.f -----
+incdir+rtl/core
rtl/core/lb_pkg.sv
rtl/core/lb_sqrt.sv
rtl/core/lb_div.sv
rtl/core/lorentz_boost_top.sv
tb/sv/tb_top.sv
